@@ sv/cv3_pkg.sv @@
// ----------------------------------------------------------------------------
// cv3_pkg
// Shared types and constants of the streaming 3x3 convolution block.
// ----------------------------------------------------------------------------
`default_nettype none

package cv3_pkg;

   // Field widths
   localparam int PIX_W     = 16;
   localparam int TAG_W     = 10;
   localparam int PROD_W    = 2 * PIX_W;
   localparam int ROWSUM_W  = PROD_W + 2;
   localparam int SUM_W     = 36;
   localparam int DIM_W     = 11;
   localparam int KROW_W    = 48;
   localparam int KTAPS     = 3;

   // Line memory word: newer row in the upper half, older row in the lower half
   localparam int LINE_W    = 2 * PIX_W;
   // Window column: current row, row above, row two above (low bits)
   localparam int COL_W     = 3 * PIX_W;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = KROW_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KERNEL_TOP    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KERNEL_MIDDLE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_KERNEL_BOTTOM = 3'd4;

   localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

   // Results one pixel can cause, in delivery order
   localparam int EMIT_KINDS = 4;
   typedef enum logic [1:0] {
      EMIT_PREV_MID,   // row above, column to the left
      EMIT_PREV_END,   // row above, last column
      EMIT_LAST_MID,   // last row, column to the left
      EMIT_LAST_END    // last row, last column
   } emit_kind_type;

   // 3x3 grid of 16-bit values, index [kernel row][kernel column]
   typedef logic [KTAPS-1:0][KTAPS-1:0][PIX_W-1:0] taps_type;

   // Position of a pixel and the results it causes
   typedef struct packed {
      logic [TAG_W-1:0]      row;
      logic [TAG_W-1:0]      col;
      logic                  row_ge1;
      logic                  row_ge2;
      logic                  col_ge1;
      logic                  col_ge2;
      logic [EMIT_KINDS-1:0] mask;
   } pos_type;

   // Tag that travels with one result
   typedef struct packed {
      logic [TAG_W-1:0] row;
      logic [TAG_W-1:0] col;
      logic             last;
   } tag_type;

endpackage

`default_nettype wire

@@ sv/cv3_line_mem.sv @@
// ----------------------------------------------------------------------------
// cv3_line_mem
// Line memory holding the two previous image rows, one packed word per column.
// Clears itself after reset and forwards a write to a same-address read.
// ----------------------------------------------------------------------------
`default_nettype none

module cv3_line_mem
   import cv3_pkg::*;
#(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rd_en,
   input  wire logic [AW-1:0]     rd_addr,
   output logic      [LINE_W-1:0] rd_data,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [LINE_W-1:0] wr_data,
   output logic                   busy
);

   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

   logic [LINE_W-1:0] ram_ff [DEPTH];
   logic [LINE_W-1:0] q_ff;
   logic [LINE_W-1:0] fwd_data_ff;
   logic              fwd_hit_ff;
   logic              clear_ff;
   logic [AW-1:0]     clear_addr_ff;

   // Sweep every entry to zero after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clear_ff) begin
         clear_addr_ff <= clear_addr_ff + AW'(1);
         if (clear_addr_ff == LAST_ADDR) begin
            clear_ff <= 1'b0;
         end
      end
   end

   // Write port
   always_ff @(posedge clock) begin
      if (clear_ff) begin
         ram_ff[clear_addr_ff] <= '0;
      end else if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; hold the data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         q_ff <= ram_ff[rd_addr];
      end
   end

   // Catch a write landing on the entry being read in the same cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_hit_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_hit_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         fwd_data_ff <= wr_data;
      end
   end

   assign rd_data = fwd_hit_ff ? fwd_data_ff : q_ff;
   assign busy    = clear_ff;

endmodule

`default_nettype wire

@@ sv/cv3_window.sv @@
// ----------------------------------------------------------------------------
// cv3_window
// Three-column window over the last pixels and the result sequencer: issues
// the masked 3x3 taps of each result a pixel causes, one result per cycle unless the pipeline stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module cv3_window
   import cv3_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire logic [COL_W-1:0] in_column,
   input  wire pos_type          in_pos,
   output logic                  in_take,
   input  wire logic             emit_ready,
   output logic                  emit_valid,
   output taps_type              emit_taps,
   output tag_type               emit_tag
);

   logic [COL_W-1:0]                   win_ff [KTAPS];
   pos_type                            pos_ff;
   logic [EMIT_KINDS-1:0]              mask_ff;
   logic [EMIT_KINDS-1:0]              sel_mask;
   emit_kind_type                      kind;
   logic                               shift;
   logic                               base;
   logic                               top_ok;
   logic                               bottom_ok;
   logic                               left_ok;
   logic                               right_ok;
   logic [KTAPS:0][KTAPS:0][PIX_W-1:0] grid;

   // Pick the next pending result in delivery order
   always_comb begin
      kind = EMIT_PREV_MID;
      if (mask_ff[EMIT_PREV_MID]) begin
         kind = EMIT_PREV_MID;
      end else if (mask_ff[EMIT_PREV_END]) begin
         kind = EMIT_PREV_END;
      end else if (mask_ff[EMIT_LAST_MID]) begin
         kind = EMIT_LAST_MID;
      end else if (mask_ff[EMIT_LAST_END]) begin
         kind = EMIT_LAST_END;
      end
      sel_mask       = '0;
      sel_mask[kind] = 1'b1;
   end

   // Center column and lane offset of the chosen result
   always_comb begin
      case (kind)
         EMIT_PREV_MID: begin
            shift = 1'b0;
            base  = 1'b0;
         end
         EMIT_PREV_END: begin
            shift = 1'b1;
            base  = 1'b0;
         end
         EMIT_LAST_MID: begin
            shift = 1'b0;
            base  = 1'b1;
         end
         EMIT_LAST_END: begin
            shift = 1'b1;
            base  = 1'b1;
         end
         default: begin
            shift = 1'b0;
            base  = 1'b0;
         end
      endcase
      top_ok    = base ? pos_ff.row_ge1 : pos_ff.row_ge2;
      bottom_ok = !base;
      left_ok   = shift ? pos_ff.col_ge1 : pos_ff.col_ge2;
      right_ok  = !shift;
   end

   // Window as a 4x4 grid; the extra column and lane read as zero
   always_comb begin
      grid = '0;
      for (int wc = 0; wc < KTAPS; wc++) begin
         for (int ln = 0; ln < KTAPS; ln++) begin
            grid[wc][ln] = win_ff[wc][ln*PIX_W +: PIX_W];
         end
      end
   end

   // Gather taps, zero those that fall outside the image
   always_comb begin
      logic tap_on;
      for (int kr = 0; kr < KTAPS; kr++) begin
         for (int kc = 0; kc < KTAPS; kc++) begin
            tap_on = !((kr == 0) && !top_ok) && !((kr == KTAPS-1) && !bottom_ok) &&
                     !((kc == 0) && !left_ok) && !((kc == KTAPS-1) && !right_ok);
            emit_taps[kr][kc] = tap_on ? grid[2'(kc) + 2'(shift)][2'(kr) + 2'(base)] : '0;
         end
      end
   end

   always_comb begin
      emit_tag.row  = base  ? pos_ff.row : pos_ff.row - TAG_W'(1);
      emit_tag.col  = shift ? pos_ff.col : pos_ff.col - TAG_W'(1);
      emit_tag.last = (mask_ff & ~sel_mask) == '0;
   end

   assign emit_valid = |mask_ff;
   assign in_take    = (mask_ff == '0) || (emit_ready && $onehot(mask_ff));

   // Shift the window on a new column; drop each result once issued
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
         for (int i = 0; i < KTAPS; i++) begin
            win_ff[i] <= '0;
         end
      end else if (in_valid && in_take) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= in_column;
         mask_ff   <= in_pos.mask;
      end else if (emit_valid && emit_ready) begin
         mask_ff <= mask_ff & ~sel_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_take) begin
         pos_ff <= in_pos;
      end
   end

endmodule

`default_nettype wire

@@ sv/cv3_mac.sv @@
// ----------------------------------------------------------------------------
// cv3_mac
// Multiply-accumulate pipeline: registers taps, forms nine products in
// parallel, adds per kernel row, then adds the rows into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cv3_mac
   import cv3_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire taps_type           kernel,
   input  wire logic               in_valid,
   input  wire taps_type           in_taps,
   input  wire tag_type            in_tag,
   output logic                    in_ready,
   output logic                    out_valid,
   input  wire logic               out_stall,
   output logic        [TAG_W-1:0] out_row,
   output logic        [TAG_W-1:0] out_col,
   output logic signed [SUM_W-1:0] out_filtered,
   output logic                    out_last
);

   logic                       s3_valid_ff;
   logic                       s4_valid_ff;
   logic                       s5_valid_ff;
   logic                       s6_valid_ff;
   logic                       rdy3;
   logic                       rdy4;
   logic                       rdy5;
   logic                       rdy6;
   taps_type                   s3_taps_ff;
   tag_type                    s3_tag_ff;
   tag_type                    s4_tag_ff;
   tag_type                    s5_tag_ff;
   tag_type                    s6_tag_ff;
   logic signed [PROD_W-1:0]   s4_prod_ff [KTAPS][KTAPS];
   logic signed [ROWSUM_W-1:0] s5_row_ff  [KTAPS];
   logic signed [SUM_W-1:0]    s6_sum_ff;

   // Advance a stage when the one after it has room
   assign rdy6     = !s6_valid_ff || !out_stall;
   assign rdy5     = !s5_valid_ff || rdy6;
   assign rdy4     = !s4_valid_ff || rdy5;
   assign rdy3     = !s3_valid_ff || rdy4;
   assign in_ready = rdy3;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else begin
         if (rdy3) s3_valid_ff <= in_valid;
         if (rdy4) s4_valid_ff <= s3_valid_ff;
         if (rdy5) s5_valid_ff <= s4_valid_ff;
         if (rdy6) s6_valid_ff <= s5_valid_ff;
      end
   end

   // Capture taps
   always_ff @(posedge clock) begin
      if (rdy3) begin
         s3_taps_ff <= in_taps;
         s3_tag_ff  <= in_tag;
      end
   end

   // Nine signed 16x16 products
   always_ff @(posedge clock) begin
      if (rdy4) begin
         s4_tag_ff <= s3_tag_ff;
         for (int kr = 0; kr < KTAPS; kr++) begin
            for (int kc = 0; kc < KTAPS; kc++) begin
               s4_prod_ff[kr][kc] <= $signed(s3_taps_ff[kr][kc]) * $signed(kernel[kr][kc]);
            end
         end
      end
   end

   // Sum each kernel row
   always_ff @(posedge clock) begin
      if (rdy5) begin
         s5_tag_ff <= s4_tag_ff;
         for (int kr = 0; kr < KTAPS; kr++) begin
            s5_row_ff[kr] <= {{2{s4_prod_ff[kr][0][PROD_W-1]}}, s4_prod_ff[kr][0]} +
                             {{2{s4_prod_ff[kr][1][PROD_W-1]}}, s4_prod_ff[kr][1]} +
                             {{2{s4_prod_ff[kr][2][PROD_W-1]}}, s4_prod_ff[kr][2]};
         end
      end
   end

   // Sum the rows into the output register
   always_ff @(posedge clock) begin
      if (rdy6) begin
         s6_tag_ff <= s5_tag_ff;
         s6_sum_ff <= {{2{s5_row_ff[0][ROWSUM_W-1]}}, s5_row_ff[0]} +
                      {{2{s5_row_ff[1][ROWSUM_W-1]}}, s5_row_ff[1]} +
                      {{2{s5_row_ff[2][ROWSUM_W-1]}}, s5_row_ff[2]};
      end
   end

   assign out_valid    = s6_valid_ff;
   assign out_row      = s6_tag_ff.row;
   assign out_col      = s6_tag_ff.col;
   assign out_last     = s6_tag_ff.last;
   assign out_filtered = s6_sum_ff;

endmodule

`default_nettype wire

@@ sv/conv3x3_zero_pad_stream.sv @@
// ----------------------------------------------------------------------------
// conv3x3_zero_pad_stream
// Streaming 3x3 convolution with zero padding over raster-order pixels.
// ----------------------------------------------------------------------------
//
//  Port group  Direction  Handshake              Carries
//  req_*       in         req_valid / req_stall  one source pixel
//  rsp_*       out        rsp_valid / rsp_stall  row, column, sum, last flag
//  csr_*       in         csr_wr_en              register index and data
//
//  A pixel is taken every cycle while req_stall is low; a pixel causing k
//  results (two at row ends and on the last row, four at the last pixel)
//  holds the input while the window feeds them to the single-result
//  multiply-accumulate pipeline. A result passes the input and window
//  registers, then the pipeline. After reset the line memory clears;
//  req_stall is high meanwhile. Configuration writes are taken at any time.
//  rsp_stall backs up through the pipeline; empty stages keep filling.
// ----------------------------------------------------------------------------
`default_nettype none

module conv3x3_zero_pad_stream
   import cv3_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // Pixel requests
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic signed [PIX_W-1:0] req_pixel,
   // Results
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic        [TAG_W-1:0]      rsp_out_row,
   output logic        [TAG_W-1:0]      rsp_out_col,
   output logic signed [SUM_W-1:0]      rsp_filtered,
   output logic                         rsp_last_of_run,
   // Configuration
   input  wire logic                    csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int EW = $clog2(MAX_WIDTH + 1);
   localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int EH = $clog2(MAX_HEIGHT + 1);

   logic [DIM_W-1:0]  width_ff;
   logic [DIM_W-1:0]  height_ff;
   logic [KROW_W-1:0] ktop_ff;
   logic [KROW_W-1:0] kmid_ff;
   logic [KROW_W-1:0] kbot_ff;
   taps_type          kernel;

   logic [EW-1:0]     eff_w;
   logic [EH-1:0]     eff_h;
   logic [AW-1:0]     col_ff;
   logic [AW-1:0]     col_in;
   logic [RW-1:0]     row_ff;
   logic [RW-1:0]     row_in;
   logic [AW-1:0]     cur_col;
   logic [RW-1:0]     cur_row;
   logic              restart;
   logic              col_last;
   logic              row_last;
   pos_type           cur_pos;

   logic              acc;
   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic              s1_adv;
   logic [PIX_W-1:0]  s1_pix_ff;
   logic [AW-1:0]     s1_addr_ff;
   pos_type           s1_pos_ff;

   logic [LINE_W-1:0] mem_rd;
   logic              mem_busy;
   logic              win_take;
   logic              emit_valid;
   logic              mac_ready;
   taps_type          emit_taps;
   tag_type           emit_tag;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
         ktop_ff   <= '0;
         kmid_ff   <= '0;
         kbot_ff   <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:   width_ff  <= csr_wdata[DIM_W-1:0];
            CSR_IMAGE_HEIGHT:  height_ff <= csr_wdata[DIM_W-1:0];
            CSR_KERNEL_TOP:    ktop_ff   <= csr_wdata;
            CSR_KERNEL_MIDDLE: kmid_ff   <= csr_wdata;
            CSR_KERNEL_BOTTOM: kbot_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign kernel = {kbot_ff, kmid_ff, ktop_ff};

   // Clamp geometry to 1..maximum
   always_comb begin
      if (width_ff == '0) begin
         eff_w = EW'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         eff_w = EW'(MAX_WIDTH);
      end else begin
         eff_w = EW'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = EH'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         eff_h = EH'(MAX_HEIGHT);
      end else begin
         eff_h = EH'(height_ff);
      end
   end

   // Raster position of the incoming pixel; restart an image out of range
   always_comb begin
      restart  = (EW'(col_ff) >= eff_w) || (EH'(row_ff) >= eff_h);
      cur_col  = restart ? '0 : col_ff;
      cur_row  = restart ? '0 : row_ff;
      col_last = EW'(cur_col) == (eff_w - EW'(1));
      row_last = EH'(cur_row) == (eff_h - EH'(1));
      if (col_last) begin
         col_in = '0;
         row_in = row_last ? '0 : cur_row + RW'(1);
      end else begin
         col_in = cur_col + AW'(1);
         row_in = cur_row;
      end
   end

   // Which results this pixel causes
   always_comb begin
      cur_pos.row                = TAG_W'(cur_row);
      cur_pos.col                = TAG_W'(cur_col);
      cur_pos.row_ge1            = cur_row != '0;
      cur_pos.row_ge2            = cur_row > RW'(1);
      cur_pos.col_ge1            = cur_col != '0;
      cur_pos.col_ge2            = cur_col > AW'(1);
      cur_pos.mask               = '0;
      cur_pos.mask[EMIT_PREV_MID] = cur_pos.row_ge1 && cur_pos.col_ge1;
      cur_pos.mask[EMIT_PREV_END] = cur_pos.row_ge1 && col_last;
      cur_pos.mask[EMIT_LAST_MID] = row_last && cur_pos.col_ge1;
      cur_pos.mask[EMIT_LAST_END] = row_last && col_last;
   end

   // Request handshake
   assign s1_adv    = s1_valid_ff && win_take;
   assign req_stall = mem_busy || (s1_valid_ff && !win_take);
   assign acc       = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (acc) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         col_ff      <= '0;
         row_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (acc) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   // Hold the pixel while its line memory read completes
   always_ff @(posedge clock) begin
      if (acc) begin
         s1_pix_ff  <= req_pixel;
         s1_addr_ff <= cur_col;
         s1_pos_ff  <= cur_pos;
      end
   end

   // Read both previous rows, write back row r-1 and the new pixel
   cv3_line_mem #(
      .DEPTH (MAX_WIDTH),
      .AW    (AW)
   ) u_line_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (acc),
      .rd_addr (cur_col),
      .rd_data (mem_rd),
      .wr_en   (s1_adv),
      .wr_addr (s1_addr_ff),
      .wr_data ({s1_pix_ff, mem_rd[LINE_W-1:PIX_W]}),
      .busy    (mem_busy)
   );

   cv3_window u_window (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (s1_valid_ff),
      .in_column  ({s1_pix_ff, mem_rd}),
      .in_pos     (s1_pos_ff),
      .in_take    (win_take),
      .emit_ready (mac_ready),
      .emit_valid (emit_valid),
      .emit_taps  (emit_taps),
      .emit_tag   (emit_tag)
   );

   cv3_mac u_mac (
      .clock        (clock),
      .reset        (reset),
      .kernel       (kernel),
      .in_valid     (emit_valid),
      .in_taps      (emit_taps),
      .in_tag       (emit_tag),
      .in_ready     (mac_ready),
      .out_valid    (rsp_valid),
      .out_stall    (rsp_stall),
      .out_row      (rsp_out_row),
      .out_col      (rsp_out_col),
      .out_filtered (rsp_filtered),
      .out_last     (rsp_last_of_run)
   );

   // No pixel may be in flight while the line memory clears
   assert property (@(posedge clock) disable iff (reset)
      mem_busy |-> !s1_valid_ff)
      else $error("pixel in flight during line memory clear");

   // A pixel waiting on the window keeps its place and address
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(s1_addr_ff)))
      else $error("waiting pixel lost or overwritten");

   // Position counters stay inside the image after each request
   assert property (@(posedge clock) disable iff (reset)
      acc |=> ((EW'(col_ff) < $past(eff_w)) && (EH'(row_ff) < $past(eff_h))))
      else $error("raster position left the image");

endmodule

`default_nettype wire
